// ----- src/tfr_pkg.sv -----
// shared constants, event codes and checksum helpers for the telemetry frame receiver
package tfr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CRC_EXTRA_EN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PARAM_MSGS_EN = 2'd2;

  localparam logic [7:0] START_MARKER_RST = 8'd254;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_DATA  = 3'd1,
    EV_OK    = 3'd2,
    EV_BADLO = 3'd3,
    EV_BADHI = 3'd4
  } event_t;

  // x.25 crc-16, one byte
  function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
  endfunction

  // per-message extra byte, unknown ids give zero
  function automatic logic [7:0] crc_extra(input logic [7:0] id, input logic param_en);
    logic [7:0] e;
    case (id)
      8'd0:    e = 8'd50;
      8'd1:    e = 8'd124;
      8'd24:   e = 8'd24;
      8'd22:   e = param_en ? 8'd220 : 8'd0;
      8'd253:  e = param_en ? 8'd83 : 8'd0;
      default: e = 8'd0;
    endcase
    return e;
  endfunction

endpackage

// ----- src/telemetry_frame_receiver.sv -----
// telemetry frame receiver: byte-serial v1 frame parser with streamed payload
//
//   channel   signals                           direction  beat
//   rx        rx_valid rx_stall rx_byte         in         one received byte
//   result    res_valid res_stall event_res ..  out        one result per byte
//   cfg       cfg_we cfg_index cfg_data         in         one register write
//
// the crc update, extra-byte lookup and phase step sit between the parser state
// and the result register, so a result appears the cycle after its byte is taken
// and a byte can be taken every cycle while rx_stall is low.
// rx_stall rises only while a result is held and res_stall is high.
// synchronous reset returns the parser to idle with crc 0xFFFF and config at defaults.
module telemetry_frame_receiver import tfr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [2:0]          event_res,
  output logic [7:0]          data_byte,
  output logic [7:0]          byte_index,
  output logic [7:0]          payload_len,
  output logic [7:0]          seq_num,
  output logic [7:0]          sys_id,
  output logic [7:0]          comp_id,
  output logic [7:0]          msg_id,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STX     = 4'd1,
    PH_LEN     = 4'd2,
    PH_SEQ     = 4'd3,
    PH_SYS     = 4'd4,
    PH_COMP    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRCLO   = 4'd7,
    PH_CRCHI   = 4'd8
  } phase_t;

  logic [7:0]  start_marker;
  logic        crc_extra_enable;
  logic        param_msgs_enable;

  phase_t      parse_phase, parse_phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  frame_seq, frame_seq_next;
  logic [7:0]  frame_sys, frame_sys_next;
  logic [7:0]  frame_comp, frame_comp_next;
  logic [7:0]  frame_msg, frame_msg_next;
  event_t      ev_next;
  logic [7:0]  idx_next;

  logic        rx_take;
  logic [7:0]  crc_in;
  logic [15:0] crc_upd;
  logic [15:0] crc_chk;
  logic [7:0]  count_inc;
  logic        is_marker;

  assign rx_stall = res_valid & res_stall;
  assign rx_take  = rx_valid & ~rx_stall;

  assign is_marker = (rx_byte == start_marker);
  assign count_inc = payload_count + 8'd1;
  // the checksum low phase folds the extra byte instead of the received one
  assign crc_in  = (parse_phase == PH_CRCLO) ? crc_extra(frame_msg, param_msgs_enable) : rx_byte;
  assign crc_upd = x25_update(running_crc, crc_in);
  assign crc_chk = crc_extra_enable ? crc_upd : running_crc;

  always_comb begin
    parse_phase_next   = parse_phase;
    running_crc_next   = running_crc;
    frame_len_next     = frame_len;
    payload_count_next = payload_count;
    frame_seq_next     = frame_seq;
    frame_sys_next     = frame_sys;
    frame_comp_next    = frame_comp;
    frame_msg_next     = frame_msg;
    ev_next            = EV_NONE;
    idx_next           = 8'd0;
    case (parse_phase)
      PH_STX: begin
        frame_len_next     = rx_byte;
        payload_count_next = 8'd0;
        running_crc_next   = crc_upd;
        parse_phase_next   = PH_LEN;
      end
      PH_LEN: begin
        frame_seq_next   = rx_byte;
        running_crc_next = crc_upd;
        parse_phase_next = PH_SEQ;
      end
      PH_SEQ: begin
        frame_sys_next   = rx_byte;
        running_crc_next = crc_upd;
        parse_phase_next = PH_SYS;
      end
      PH_SYS: begin
        frame_comp_next  = rx_byte;
        running_crc_next = crc_upd;
        parse_phase_next = PH_COMP;
      end
      PH_COMP: begin
        frame_msg_next   = rx_byte;
        running_crc_next = crc_upd;
        parse_phase_next = (frame_len == 8'd0) ? PH_CRCLO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        ev_next            = EV_DATA;
        idx_next           = payload_count;
        payload_count_next = count_inc;
        running_crc_next   = crc_upd;
        if (count_inc == frame_len) begin
          parse_phase_next = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        running_crc_next = crc_chk;
        if (rx_byte != crc_chk[7:0]) begin
          ev_next = EV_BADLO;
          if (is_marker) begin
            parse_phase_next = PH_STX;
            frame_len_next   = 8'd0;
            running_crc_next = CRC_INIT;
          end else begin
            parse_phase_next = PH_IDLE;
          end
        end else begin
          parse_phase_next = PH_CRCHI;
        end
      end
      PH_CRCHI: begin
        if (rx_byte != running_crc[15:8]) begin
          ev_next = EV_BADHI;
          if (is_marker) begin
            parse_phase_next = PH_STX;
            frame_len_next   = 8'd0;
            running_crc_next = CRC_INIT;
          end else begin
            parse_phase_next = PH_IDLE;
          end
        end else begin
          ev_next          = EV_OK;
          parse_phase_next = PH_IDLE;
        end
      end
      default: begin
        if (is_marker) begin
          parse_phase_next = PH_STX;
          frame_len_next   = 8'd0;
          running_crc_next = CRC_INIT;
        end else begin
          parse_phase_next = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker      <= START_MARKER_RST;
      crc_extra_enable  <= 1'b1;
      param_msgs_enable <= 1'b1;
      parse_phase       <= PH_IDLE;
      running_crc       <= CRC_INIT;
      frame_len         <= 8'd0;
      payload_count     <= 8'd0;
      frame_seq         <= 8'd0;
      frame_sys         <= 8'd0;
      frame_comp        <= 8'd0;
      frame_msg         <= 8'd0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_MARKER:  start_marker      <= cfg_data;
          CFG_CRC_EXTRA_EN:  crc_extra_enable  <= cfg_data[0];
          CFG_PARAM_MSGS_EN: param_msgs_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (rx_take) begin
        parse_phase   <= parse_phase_next;
        running_crc   <= running_crc_next;
        frame_len     <= frame_len_next;
        payload_count <= payload_count_next;
        frame_seq     <= frame_seq_next;
        frame_sys     <= frame_sys_next;
        frame_comp    <= frame_comp_next;
        frame_msg     <= frame_msg_next;
        event_res     <= ev_next;
        data_byte     <= rx_byte;
        byte_index    <= idx_next;
        payload_len   <= frame_len_next;
        seq_num       <= frame_seq_next;
        sys_id        <= frame_sys_next;
        comp_id       <= frame_comp_next;
        msg_id        <= frame_msg_next;
      end
      if (rx_take) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/tfr_checker.sv -----
// port-level checks for the telemetry frame receiver, bound to the top level
module tfr_checker import tfr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] event_res,
  input logic [7:0] data_byte,
  input logic [7:0] byte_index
);

  // a held result keeps its beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(data_byte)
      && $stable(byte_index))
    else $error("stalled result changed");

  // every taken byte shows up as a result the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    rx_valid && !rx_stall |=> res_valid)
    else $error("taken byte gave no result");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid && res_stall)
    else $error("input stalled without a held result");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> event_res == EV_NONE || event_res == EV_DATA || event_res == EV_OK
      || event_res == EV_BADLO || event_res == EV_BADHI)
    else $error("event code out of range");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_DATA |-> byte_index == 8'd0)
    else $error("index set on a non-payload beat");

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_valid   (rx_valid),
  .rx_stall   (rx_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .event_res  (event_res),
  .data_byte  (data_byte),
  .byte_index (byte_index)
);

// ----- dv/telemetry_frame_receiver_tb.sv -----
// self-checking testbench for the telemetry frame receiver: directed frames, then random traffic
module telemetry_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfr_pkg::*;

  typedef enum logic [3:0] {
    PHASE_IDLE, PHASE_START, PHASE_LEN, PHASE_SEQ, PHASE_SYS, PHASE_COMP,
    PHASE_PAYLOAD, PHASE_CK_LO, PHASE_CK_HI
  } parse_phase_t;

  typedef enum logic [1:0] {ROW_LIT, ROW_MARKER, ROW_CK_GOOD, ROW_CK_BAD} row_kind_t;

  typedef enum int {CK_CLEAN, CK_BAD_LO, CK_BAD_HI, CK_MARKER_LO, CK_MARKER_HI} ck_plan_t;

  typedef struct {
    event_t     ev;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] len;
    logic [7:0] seq;
    logic [7:0] sys;
    logic [7:0] comp;
    logic [7:0] msg;
  } frame_result_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
    event_t     ev;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam int PRINT_CAP = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  logic [7:0] rx_byte = 8'd0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [2:0] event_res;
  logic [7:0] data_byte, byte_index, payload_len, seq_num, sys_id, comp_id, msg_id;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_START_MARKER;
  logic [CfgDataW-1:0] cfg_data = '0;

  // parser copy: configuration and state
  logic [7:0] marker_cfg;
  logic extra_en_cfg, param_en_cfg;
  parse_phase_t cur_phase;
  logic [15:0] crc_acc;
  logic [7:0] hdr_len, pay_cnt, hdr_seq, hdr_sys, hdr_comp, hdr_msg;

  frame_result_t results_due[$];
  int mismatches = 0;
  int items_done = 0;
  int stall_left = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  // expected event typed per row; the other fields come from the parser copy
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_LIT, 8'h00, EV_NONE},
    '{ROW_LIT, 8'hFF, EV_NONE},
    // empty payload, id 0, high checksum byte wrong
    '{ROW_MARKER, 8'h00, EV_NONE},
    '{ROW_LIT, 8'h00, EV_NONE},
    '{ROW_LIT, 8'hFF, EV_NONE},
    '{ROW_LIT, 8'h00, EV_NONE},
    '{ROW_LIT, 8'hFF, EV_NONE},
    '{ROW_LIT, 8'h00, EV_NONE},
    '{ROW_CK_GOOD, 8'h00, EV_NONE},
    '{ROW_CK_BAD, 8'h00, EV_BADHI},
    // one payload byte, id 22, low checksum byte wrong
    '{ROW_MARKER, 8'h00, EV_NONE},
    '{ROW_LIT, 8'h01, EV_NONE},
    '{ROW_LIT, 8'h55, EV_NONE},
    '{ROW_LIT, 8'hAA, EV_NONE},
    '{ROW_LIT, 8'h80, EV_NONE},
    '{ROW_LIT, 8'd22, EV_NONE},
    '{ROW_LIT, 8'h00, EV_DATA},
    '{ROW_CK_BAD, 8'h00, EV_BADLO},
    // two payload bytes, id 253, marker value inside the frame, good checksum
    '{ROW_MARKER, 8'h00, EV_NONE},
    '{ROW_LIT, 8'h02, EV_NONE},
    '{ROW_LIT, 8'h7F, EV_NONE},
    '{ROW_LIT, 8'h01, EV_NONE},
    '{ROW_LIT, 8'hFE, EV_NONE},
    '{ROW_LIT, 8'd253, EV_NONE},
    '{ROW_LIT, 8'hFE, EV_DATA},
    '{ROW_LIT, 8'hFF, EV_DATA},
    '{ROW_CK_GOOD, 8'h00, EV_NONE},
    '{ROW_CK_GOOD, 8'h00, EV_OK}
  };

  telemetry_frame_receiver u_dut (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .event_res   (event_res),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .payload_len (payload_len),
    .seq_num     (seq_num),
    .sys_id      (sys_id),
    .comp_id     (comp_id),
    .msg_id      (msg_id),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_x25(logic [15:0] acc, logic [7:0] b);
    logic [15:0] t;
    t = {8'd0, b ^ acc[7:0]};
    t = (t ^ (t << 4)) & 16'h00FF;
    return (acc >> 8) ^ (t << 8) ^ (t << 3) ^ (t >> 4);
  endfunction

  function automatic logic [7:0] msg_extra(logic [7:0] id);
    case (id)
      8'd0:    return 8'd50;
      8'd1:    return 8'd124;
      8'd24:   return 8'd24;
      8'd22:   return param_en_cfg ? 8'd220 : 8'd0;
      8'd253:  return param_en_cfg ? 8'd83 : 8'd0;
      default: return 8'd0;
    endcase
  endfunction

  // checksum the low byte is compared with, extra byte folded in when enabled
  function automatic logic [15:0] folded_check();
    return extra_en_cfg ? crc16_x25(crc_acc, msg_extra(hdr_msg)) : crc_acc;
  endfunction

  function automatic void parser_reset();
    marker_cfg = START_MARKER_RST;
    extra_en_cfg = 1'b1;
    param_en_cfg = 1'b1;
    cur_phase = PHASE_IDLE;
    crc_acc = CRC_INIT;
    hdr_len = 8'd0;
    pay_cnt = 8'd0;
    hdr_seq = 8'd0;
    hdr_sys = 8'd0;
    hdr_comp = 8'd0;
    hdr_msg = 8'd0;
  endfunction

  function automatic void resync_on(logic [7:0] c);
    if (c == marker_cfg) begin
      cur_phase = PHASE_START;
      hdr_len = 8'd0;
      crc_acc = CRC_INIT;
    end else begin
      cur_phase = PHASE_IDLE;
    end
  endfunction

  function automatic frame_result_t parse_byte(logic [7:0] c);
    frame_result_t r;
    r.ev = EV_NONE;
    r.data = c;
    r.index = 8'd0;
    case (cur_phase)
      PHASE_START: begin
        hdr_len = c;
        pay_cnt = 8'd0;
        crc_acc = crc16_x25(crc_acc, c);
        cur_phase = PHASE_LEN;
      end
      PHASE_LEN: begin
        hdr_seq = c;
        crc_acc = crc16_x25(crc_acc, c);
        cur_phase = PHASE_SEQ;
      end
      PHASE_SEQ: begin
        hdr_sys = c;
        crc_acc = crc16_x25(crc_acc, c);
        cur_phase = PHASE_SYS;
      end
      PHASE_SYS: begin
        hdr_comp = c;
        crc_acc = crc16_x25(crc_acc, c);
        cur_phase = PHASE_COMP;
      end
      PHASE_COMP: begin
        hdr_msg = c;
        crc_acc = crc16_x25(crc_acc, c);
        cur_phase = (hdr_len == 8'd0) ? PHASE_CK_LO : PHASE_PAYLOAD;
      end
      PHASE_PAYLOAD: begin
        r.ev = EV_DATA;
        r.index = pay_cnt;
        pay_cnt = pay_cnt + 8'd1;
        crc_acc = crc16_x25(crc_acc, c);
        if (pay_cnt == hdr_len) cur_phase = PHASE_CK_LO;
      end
      PHASE_CK_LO: begin
        crc_acc = folded_check();
        if (c != crc_acc[7:0]) begin
          r.ev = EV_BADLO;
          resync_on(c);
        end else begin
          cur_phase = PHASE_CK_HI;
        end
      end
      PHASE_CK_HI: begin
        if (c != crc_acc[15:8]) begin
          r.ev = EV_BADHI;
          resync_on(c);
        end else begin
          r.ev = EV_OK;
          cur_phase = PHASE_IDLE;
        end
      end
      default: resync_on(c);
    endcase
    r.len = hdr_len;
    r.seq = hdr_seq;
    r.sys = hdr_sys;
    r.comp = hdr_comp;
    r.msg = hdr_msg;
    return r;
  endfunction

  function automatic logic [7:0] good_check_byte();
    logic [15:0] v;
    if (cur_phase == PHASE_CK_LO) begin
      v = folded_check();
      return v[7:0];
    end
    return crc_acc[15:8];
  endfunction

  // wrong checksum byte that does not reopen a frame
  function automatic logic [7:0] bad_check_byte();
    logic [7:0] g, b;
    g = good_check_byte();
    do b = g ^ 8'($urandom_range(1, 255)); while (b == marker_cfg);
    return b;
  endfunction

  function automatic logic [7:0] row_byte(dir_row_t row);
    case (row.kind)
      ROW_MARKER:  return marker_cfg;
      ROW_CK_GOOD: return good_check_byte();
      ROW_CK_BAD:  return bad_check_byte();
      default:     return row.b;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 40);
    if (r < 99) return $urandom_range(41, 120);
    return $urandom_range(0, 1) ? 255 : $urandom_range(200, 254);
  endfunction

  function automatic logic [7:0] pick_msg();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd22;
      3:       return 8'd24;
      4:       return 8'd253;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic ck_plan_t pick_ck_plan();
    case ($urandom_range(0, 15))
      0:       return CK_BAD_LO;
      1:       return CK_BAD_HI;
      2:       return CK_MARKER_LO;
      3:       return CK_MARKER_HI;
      default: return CK_CLEAN;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // one beat on the rx side; the expectation is queued once the beat is taken
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input event_t typed_ev = EV_NONE);
    int gap;
    frame_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_stall);
    if (cur_phase != PHASE_IDLE || b == marker_cfg) items_done++;
    r = parse_byte(b);
    if (typed) r.ev = typed_ev;
    results_due.push_back(r);
  endtask

  task automatic drain_results();
    rx_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(logic [7:0] marker, logic extra_en, logic param_en);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data <= marker;
    @(posedge clk);
    cfg_index <= CFG_CRC_EXTRA_EN;
    cfg_data <= CfgDataW'(extra_en);
    @(posedge clk);
    cfg_index <= CFG_PARAM_MSGS_EN;
    cfg_data <= CfgDataW'(param_en);
    @(posedge clk);
    cfg_we <= 1'b0;
    marker_cfg = marker;
    extra_en_cfg = extra_en;
    param_en_cfg = param_en;
  endtask

  // run out whatever frame is open so the next marker really starts a frame
  task automatic finish_open_frame();
    while (cur_phase != PHASE_IDLE) begin
      case (cur_phase)
        PHASE_START:              send_byte(8'($urandom_range(0, 4)));
        PHASE_CK_LO, PHASE_CK_HI: send_byte(good_check_byte());
        default:                  send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic send_frame(ck_plan_t plan, int len);
    finish_open_frame();
    send_byte(marker_cfg);
    send_byte(8'(len));
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    send_byte(pick_msg());
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    case (plan)
      CK_BAD_LO:    send_byte(bad_check_byte());
      CK_MARKER_LO: send_byte(marker_cfg);
      default:      send_byte(good_check_byte());
    endcase
    if (cur_phase == PHASE_CK_HI) begin
      case (plan)
        CK_BAD_HI:    send_byte(bad_check_byte());
        CK_MARKER_HI: send_byte(marker_cfg);
        default:      send_byte(good_check_byte());
      endcase
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) send_byte(($urandom_range(0, 15) == 0) ? marker_cfg : 8'($urandom_range(0, 255)));
  endtask

  // result side stalls; a hold request keeps it stalled long enough to back up the input
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 150;
    end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing due, data_byte %02h", data_byte));
      end else begin
        want = results_due.pop_front();
        check_field("event_res", 8'(event_res), 8'(want.ev));
        check_field("data_byte", data_byte, want.data);
        check_field("byte_index", byte_index, want.index);
        check_field("payload_len", payload_len, want.len);
        check_field("seq_num", seq_num, want.seq);
        check_field("sys_id", sys_id, want.sys);
        check_field("comp_id", comp_id, want.comp);
        check_field("msg_id", msg_id, want.msg);
      end
    end
  end

  initial begin : stimulus
    int target;
    parser_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_byte(row_byte(dir_rows[i]), 1'b1, dir_rows[i].ev);
    for (int p = 0; p < 7; p++) begin
      drain_results();
      quiet = (p == 2);
      case (p)
        0: load_config(8'h00, 1'b1, 1'b0);
        1: load_config(8'hFF, 1'b0, 1'b1);
        2: load_config(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        3: load_config(START_MARKER_RST, 1'b1, 1'b1);
        4: load_config(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        5: load_config(8'h55, 1'b1, 1'b0);
        default: load_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
      endcase
      target = items_done + 260;
      if (p == 3) begin
        send_frame(CK_CLEAN, 12);
        hold_req = 1'b1;
      end
      if (p == 5) send_frame(CK_CLEAN, 255);
      while (items_done < target) begin
        if ($urandom_range(0, 99) < 8) send_noise();
        else send_frame(pick_ck_plan(), pick_len());
      end
    end
    drain_results();
    if (mismatches == 0) begin
      $display("telemetry_frame_receiver_tb passed");
    end else begin
      $display("telemetry_frame_receiver_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("telemetry_frame_receiver_tb failed");
    $finish;
  end

endmodule
